@@ design/vfs_pkg.sv @@
// ----------------------------------------------------------------------------
// vfs_pkg
// shared types, constants and helpers of the visibility fringe-stop block
// ----------------------------------------------------------------------------
package vfs_pkg;

  // default sizes, handed to the top-level parameters
  localparam int DEF_MAX_DISHES   = 512;
  localparam int DEF_MAX_ELEMENTS = 1024;
  localparam int DEF_PHASE_BITS   = 16;

  // fixed field widths
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam int OP_MODE_W  = 2;
  localparam int ELEM_CNT_W = 11;
  localparam int DISH_CNT_W = 10;
  localparam int SLOT_W     = 9;
  localparam int VIS_W      = 32;
  localparam int MUL_W      = 32;
  localparam int PROD_W     = 2 * MUL_W;
  localparam int ACC_W      = PROD_W + 1;
  localparam int STEP_W     = 4;

  // request kinds on the input channel
  localparam logic MODE_PHASE = 1'b0;
  localparam logic MODE_VIS   = 1'b1;

  // saturation bounds of a 32-bit result
  localparam logic signed [VIS_W-1:0] VIS_MAX = {1'b0, {(VIS_W-1){1'b1}}};
  localparam logic signed [VIS_W-1:0] VIS_MIN = {1'b1, {(VIS_W-1){1'b0}}};

  // register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OP_MODE       = 2'd0,
    CFG_ELEMENT_COUNT = 2'd1,
    CFG_DISH_COUNT    = 2'd2
  } cfg_idx_t;

  // operating modes
  typedef enum logic [OP_MODE_W-1:0] {
    OP_PASS    = 2'd0,
    OP_MULT    = 2'd1,
    OP_REPLACE = 2'd2
  } op_mode_t;

  // multiplier operand selects
  typedef enum logic [1:0] {
    A_ROW_RE = 2'd0,
    A_ROW_IM = 2'd1,
    A_VIS_RE = 2'd2,
    A_VIS_IM = 2'd3
  } a_sel_t;

  typedef enum logic [1:0] {
    B_COL_RE = 2'd0,
    B_COL_IM = 2'd1,
    B_PH_RE  = 2'd2,
    B_PH_IM  = 2'd3
  } b_sel_t;

  // where a finished product pair is rounded to
  typedef enum logic [1:0] {
    DST_PH_RE  = 2'd0,
    DST_PH_IM  = 2'd1,
    DST_OUT_RE = 2'd2,
    DST_OUT_IM = 2'd3
  } dst_t;

  // one step of the multiply-accumulate sequence
  typedef struct packed {
    logic   issue;
    a_sel_t a_sel;
    b_sel_t b_sel;
    logic   first;
    logic   neg;
    dst_t   dst;
  } mac_ctl_t;

  // controller to datapath
  typedef struct packed {
    logic     vis_load;
    logic     out_load;
    op_mode_t op_mode;
    mac_ctl_t step;
  } dp_ctl_t;

  // last step of the sequence; the result is handed over here
  localparam logic [STEP_W-1:0] MAC_LAST_STEP = 4'd11;

  // step schedule: phase product first, then the visibility product
  // a gap after step 4 lets the imaginary phase part settle
  function automatic mac_ctl_t mac_step(input logic [STEP_W-1:0] step);
    mac_ctl_t c;
    c = '{issue: 1'b0, a_sel: A_ROW_RE, b_sel: B_COL_RE, first: 1'b0, neg: 1'b0,
          dst: DST_PH_RE};
    case (step)
      4'd0: c = '{issue: 1'b1, a_sel: A_ROW_RE, b_sel: B_COL_RE, first: 1'b1,
                  neg: 1'b0, dst: DST_PH_RE};
      4'd1: c = '{issue: 1'b1, a_sel: A_ROW_IM, b_sel: B_COL_IM, first: 1'b0,
                  neg: 1'b0, dst: DST_PH_RE};
      4'd2: c = '{issue: 1'b1, a_sel: A_ROW_IM, b_sel: B_COL_RE, first: 1'b1,
                  neg: 1'b0, dst: DST_PH_IM};
      4'd3: c = '{issue: 1'b1, a_sel: A_ROW_RE, b_sel: B_COL_IM, first: 1'b0,
                  neg: 1'b1, dst: DST_PH_IM};
      4'd4: c = '{issue: 1'b1, a_sel: A_VIS_RE, b_sel: B_PH_RE, first: 1'b1,
                  neg: 1'b0, dst: DST_OUT_RE};
      4'd6: c = '{issue: 1'b1, a_sel: A_VIS_IM, b_sel: B_PH_IM, first: 1'b0,
                  neg: 1'b1, dst: DST_OUT_RE};
      4'd7: c = '{issue: 1'b1, a_sel: A_VIS_RE, b_sel: B_PH_IM, first: 1'b1,
                  neg: 1'b0, dst: DST_OUT_IM};
      4'd8: c = '{issue: 1'b1, a_sel: A_VIS_IM, b_sel: B_PH_RE, first: 1'b0,
                  neg: 1'b0, dst: DST_OUT_IM};
      default: ;
    endcase
    return c;
  endfunction

  // clamp a wide signed value to 32 bits
  function automatic logic signed [VIS_W-1:0] sat32(input logic signed [ACC_W-1:0] x);
    logic signed [VIS_W-1:0] r;
    if (x > ACC_W'(VIS_MAX)) begin
      r = VIS_MAX;
    end else if (x < ACC_W'(VIS_MIN)) begin
      r = VIS_MIN;
    end else begin
      r = x[VIS_W-1:0];
    end
    return r;
  endfunction

endpackage

@@ design/vfs_if.sv @@
// ----------------------------------------------------------------------------
// vfs_if
// request channels of the fringe-stop block: input items and results
// ----------------------------------------------------------------------------
interface vfs_in_if import vfs_pkg::*; #(
  parameter int PHASE_BITS = DEF_PHASE_BITS
);
  logic                         valid;
  logic                         ready;
  logic                         mode;
  logic [SLOT_W-1:0]            phase_slot;
  logic signed [PHASE_BITS-1:0] phase_re;
  logic signed [PHASE_BITS-1:0] phase_im;
  logic signed [VIS_W-1:0]      vis_re;
  logic signed [VIS_W-1:0]      vis_im;

  modport source (
    output valid, mode, phase_slot, phase_re, phase_im, vis_re, vis_im,
    input  ready
  );
  modport sink (
    input  valid, mode, phase_slot, phase_re, phase_im, vis_re, vis_im,
    output ready
  );
endinterface

interface vfs_out_if import vfs_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic signed [VIS_W-1:0] out_re;
  logic signed [VIS_W-1:0] out_im;
  logic                    last_of_frame;

  modport source (
    output valid, out_re, out_im, last_of_frame,
    input  ready
  );
  modport sink (
    input  valid, out_re, out_im, last_of_frame,
    output ready
  );
endinterface

@@ design/vfs_phase_mem.sv @@
// ----------------------------------------------------------------------------
// vfs_phase_mem
// per-dish phase table: one write port, two registered read ports,
// swept to unit phase after reset
// ----------------------------------------------------------------------------
module vfs_phase_mem import vfs_pkg::*; #(
  parameter int MAX_DISHES = DEF_MAX_DISHES,
  parameter int PHASE_BITS = DEF_PHASE_BITS,
  localparam int AW = (MAX_DISHES > 1) ? $clog2(MAX_DISHES) : 1,
  localparam int DW = 2 * PHASE_BITS
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr_row,
  input  logic [AW-1:0] rd_addr_col,
  output logic [DW-1:0] rd_data_row,
  output logic [DW-1:0] rd_data_col,
  output logic          clr_busy
);

  // near-unit phase: re = 2^(PHASE_BITS-1)-1, im = 0
  localparam logic [DW-1:0] UNIT_PHASE = {1'b0, {(PHASE_BITS-1){1'b1}}, {PHASE_BITS{1'b0}}};

  logic [DW-1:0] mem [MAX_DISHES];
  logic [AW-1:0] clr_addr;

  // clearing sweep, one entry a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
    end else if (clr_busy) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == AW'(MAX_DISHES - 1)) begin
        clr_busy <= 1'b0;
      end
    end
  end

  // write port, shared by the sweep and phase requests
  always_ff @(posedge clk) begin
    if (clr_busy) begin
      mem[clr_addr] <= UNIT_PHASE;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // two read ports, registered
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_row <= mem[rd_addr_row];
      rd_data_col <= mem[rd_addr_col];
    end
  end

endmodule

@@ design/vfs_ctrl.sv @@
// ----------------------------------------------------------------------------
// vfs_ctrl
// configuration registers, triangle position, sequencer and result valid
// ----------------------------------------------------------------------------
module vfs_ctrl import vfs_pkg::*; #(
  parameter int MAX_DISHES   = DEF_MAX_DISHES,
  parameter int MAX_ELEMENTS = DEF_MAX_ELEMENTS,
  localparam int AW = (MAX_DISHES > 1) ? $clog2(MAX_DISHES) : 1,
  localparam int EW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  input  logic                  in_mode,
  input  logic [SLOT_W-1:0]     in_slot,
  output logic                  in_ready,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic                  out_last,
  input  logic                  clr_busy,
  output logic                  mem_wr_en,
  output logic [AW-1:0]         mem_wr_addr,
  output logic                  mem_rd_en,
  output logic [AW-1:0]         rd_addr_row,
  output logic [AW-1:0]         rd_addr_col,
  output dp_ctl_t               dp
);

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_BUSY  = 3'b100
  } state_t;

  state_t            state, state_next;
  logic [STEP_W-1:0] step_cnt;
  op_mode_t          op_mode;
  logic [EW-1:0]     e_last, e_last_next;
  logic [AW-1:0]     d_last, d_last_next;
  logic [EW-1:0]     row_idx, col_idx;
  logic [AW-1:0]     row_dish, col_dish, row_dish_inc, col_dish_inc;
  logic              last_pend;
  logic              in_acc, vis_acc, ph_acc, slot_ok;
  logic              step_end, out_load, frame_last, pos_clr;
  logic [ELEM_CNT_W-1:0] elem_val;
  logic [DISH_CNT_W-1:0] dish_val;

  // handshake and strobes
  always_comb begin
    in_ready   = (state == ST_IDLE);
    in_acc     = in_valid && in_ready;
    vis_acc    = in_acc && (in_mode == MODE_VIS);
    ph_acc     = in_acc && (in_mode == MODE_PHASE);
    slot_ok    = (32'(in_slot) < MAX_DISHES);
    step_end   = (state == ST_BUSY) && (step_cnt == MAC_LAST_STEP);
    out_load   = step_end && (!out_valid || out_ready);
    frame_last = (row_idx == e_last) && (col_idx == e_last);
    pos_clr    = ph_acc || (cfg_we && ((cfg_idx == CFG_ELEMENT_COUNT) ||
                                       (cfg_idx == CFG_DISH_COUNT)));
  end

  // clamped counts, kept as last index
  always_comb begin
    elem_val = cfg_wdata[ELEM_CNT_W-1:0];
    dish_val = cfg_wdata[DISH_CNT_W-1:0];
    if (elem_val == '0) begin
      e_last_next = '0;
    end else if (32'(elem_val) > MAX_ELEMENTS) begin
      e_last_next = EW'(MAX_ELEMENTS - 1);
    end else begin
      e_last_next = EW'(elem_val - 1'b1);
    end
    if (dish_val == '0) begin
      d_last_next = '0;
    end else if (32'(dish_val) > MAX_DISHES) begin
      d_last_next = AW'(MAX_DISHES - 1);
    end else begin
      d_last_next = AW'(dish_val - 1'b1);
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      op_mode <= OP_MULT;
      e_last  <= '0;
      d_last  <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_OP_MODE:       op_mode <= op_mode_t'(cfg_wdata[OP_MODE_W-1:0]);
        CFG_ELEMENT_COUNT: e_last  <= e_last_next;
        CFG_DISH_COUNT:    d_last  <= d_last_next;
        default: ;
      endcase
    end
  end

  // dish wrap
  always_comb begin
    row_dish_inc = (row_dish == d_last) ? '0 : row_dish + 1'b1;
    col_dish_inc = (col_dish == d_last) ? '0 : col_dish + 1'b1;
  end

  // triangle position, row-major over the upper triangle
  always_ff @(posedge clk) begin
    if (rst || pos_clr) begin
      row_idx  <= '0;
      col_idx  <= '0;
      row_dish <= '0;
      col_dish <= '0;
    end else if (vis_acc) begin
      if (frame_last) begin
        row_idx  <= '0;
        col_idx  <= '0;
        row_dish <= '0;
        col_dish <= '0;
      end else if (col_idx != e_last) begin
        col_idx  <= col_idx + 1'b1;
        col_dish <= col_dish_inc;
      end else begin
        row_idx  <= row_idx + 1'b1;
        col_idx  <= row_idx + 1'b1;
        row_dish <= row_dish_inc;
        col_dish <= row_dish_inc;
      end
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (!clr_busy) state_next = ST_IDLE;
      ST_IDLE:  if (vis_acc) state_next = ST_BUSY;
      ST_BUSY:  if (out_load) state_next = ST_IDLE;
      default:  state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      step_cnt <= '0;
    end else begin
      state <= state_next;
      if (vis_acc) begin
        step_cnt <= '0;
      end else if ((state == ST_BUSY) && (step_cnt != MAC_LAST_STEP)) begin
        step_cnt <= step_cnt + 1'b1;
      end
    end
  end

  // frame flag follows the request
  always_ff @(posedge clk) begin
    if (vis_acc) begin
      last_pend <= frame_last;
    end
    if (out_load) begin
      out_last <= last_pend;
    end
  end

  // result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // memory requests
  always_comb begin
    mem_wr_en   = ph_acc && slot_ok;
    mem_wr_addr = AW'(in_slot);
    mem_rd_en   = vis_acc;
    rd_addr_row = row_dish;
    rd_addr_col = col_dish;
  end

  // datapath control
  always_comb begin
    dp.vis_load = vis_acc;
    dp.out_load = out_load;
    dp.op_mode  = op_mode;
    dp.step     = mac_step(step_cnt);
    if (state != ST_BUSY) begin
      dp.step.issue = 1'b0;
    end
  end

endmodule

@@ design/vfs_mac.sv @@
// ----------------------------------------------------------------------------
// vfs_mac
// shared 32x32 multiplier with accumulator; forms the phase product, then
// the corrected visibility, and holds the result payload
// ----------------------------------------------------------------------------
module vfs_mac import vfs_pkg::*; #(
  parameter int PHASE_BITS = DEF_PHASE_BITS,
  localparam int DW = 2 * PHASE_BITS
) (
  input  logic                    clk,
  input  logic                    rst,
  input  dp_ctl_t                 ctl,
  input  logic signed [VIS_W-1:0] in_vis_re,
  input  logic signed [VIS_W-1:0] in_vis_im,
  input  logic [DW-1:0]           row_phase,
  input  logic [DW-1:0]           col_phase,
  output logic signed [VIS_W-1:0] out_re,
  output logic signed [VIS_W-1:0] out_im
);

  // phase product has 2*(PHASE_BITS-1) fraction bits, brought to 30
  localparam int FRAC   = 2 * (PHASE_BITS - 1);
  localparam int PH_SHR = (FRAC > 30) ? FRAC - 30 : 0;
  localparam int PH_SHL = (FRAC < 30) ? 30 - FRAC : 0;
  localparam logic signed [ACC_W-1:0] PH_RND  = (ACC_W'(1) << PH_SHR) >> 1;
  localparam logic signed [ACC_W-1:0] VIS_RND = ACC_W'(1) << 29;
  localparam int VIS_SHR = 30;

  logic signed [PHASE_BITS-1:0] row_re, row_im, col_re, col_im;
  logic signed [VIS_W-1:0]      vr, vi, pr, pi, res_re, res_im;
  logic signed [MUL_W-1:0]      op_a, op_b;
  logic signed [PROD_W-1:0]     prod;
  mac_ctl_t                     tag;
  logic signed [ACC_W-1:0]      acc, acc_term, ph_q, vis_q;
  logic                         done_valid;
  dst_t                         done_dst;

  // phase words from the table
  always_comb begin
    row_re = row_phase[DW-1:PHASE_BITS];
    row_im = row_phase[PHASE_BITS-1:0];
    col_re = col_phase[DW-1:PHASE_BITS];
    col_im = col_phase[PHASE_BITS-1:0];
  end

  // visibility capture
  always_ff @(posedge clk) begin
    if (ctl.vis_load) begin
      vr <= in_vis_re;
      vi <= in_vis_im;
    end
  end

  // operand select
  always_comb begin
    case (ctl.step.a_sel)
      A_ROW_RE: op_a = {{(MUL_W-PHASE_BITS){row_re[PHASE_BITS-1]}}, row_re};
      A_ROW_IM: op_a = {{(MUL_W-PHASE_BITS){row_im[PHASE_BITS-1]}}, row_im};
      A_VIS_RE: op_a = vr;
      A_VIS_IM: op_a = vi;
      default:  op_a = vr;
    endcase
    case (ctl.step.b_sel)
      B_COL_RE: op_b = {{(MUL_W-PHASE_BITS){col_re[PHASE_BITS-1]}}, col_re};
      B_COL_IM: op_b = {{(MUL_W-PHASE_BITS){col_im[PHASE_BITS-1]}}, col_im};
      B_PH_RE:  op_b = pr;
      B_PH_IM:  op_b = pi;
      default:  op_b = pr;
    endcase
  end

  // multiplier stage, tag travels with the product
  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
    if (rst) begin
      tag <= '0;
    end else begin
      tag <= ctl.step;
    end
  end

  // accumulate product pairs
  always_comb begin
    acc_term = tag.neg ? -ACC_W'(prod) : ACC_W'(prod);
  end

  always_ff @(posedge clk) begin
    if (tag.issue) begin
      acc <= tag.first ? acc_term : acc + acc_term;
    end
    if (rst) begin
      done_valid <= 1'b0;
    end else begin
      done_valid <= tag.issue && !tag.first;
    end
    done_dst <= tag.dst;
  end

  // rounding of a finished pair
  always_comb begin
    ph_q  = ((acc + PH_RND) >>> PH_SHR) <<< PH_SHL;
    vis_q = (acc + VIS_RND) >>> VIS_SHR;
  end

  always_ff @(posedge clk) begin
    if (done_valid) begin
      case (done_dst)
        DST_PH_RE:  pr     <= sat32(ph_q);
        DST_PH_IM:  pi     <= sat32(ph_q);
        DST_OUT_RE: res_re <= sat32(vis_q);
        DST_OUT_IM: res_im <= sat32(vis_q);
        default: ;
      endcase
    end
  end

  // result payload register
  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      case (ctl.op_mode)
        OP_PASS: begin
          out_re <= vr;
          out_im <= vi;
        end
        OP_REPLACE: begin
          out_re <= pr;
          out_im <= pi;
        end
        default: begin
          out_re <= res_re;
          out_im <= res_im;
        end
      endcase
    end
  end

endmodule

@@ design/visibility_fringe_stop_core.sv @@
// ----------------------------------------------------------------------------
// visibility_fringe_stop_core
// fringe stopping of upper-triangle visibilities against a per-dish phase table
//
//   channel   dir  handshake      payload
//   in_ch     in   valid/ready    mode, phase_slot, phase_re, phase_im, vis_re, vis_im
//   out_ch    out  valid/ready    out_re, out_im, last_of_frame
//   cfg       in   cfg_we         cfg_idx, cfg_wdata (op_mode, element_count, dish_count)
//
// a phase request is written to the table without occupying the sequencer; a
// visibility request keeps in_ch.ready low from accept until its result is loaded
// into the output register, as the single shared 32x32 multiplier issues eight
// products per visibility (four for the phase product, four for the correction)
// after reset the phase table is swept to unit phase over all MAX_DISHES entries
// (512 by default), with in_ch.ready low; configuration writes are taken
// results sit in an output register; a new request is taken while one waits,
// and the sequencer holds at its last step while the register is still full
// ----------------------------------------------------------------------------
module visibility_fringe_stop_core import vfs_pkg::*; #(
  parameter int MAX_DISHES   = DEF_MAX_DISHES,
  parameter int MAX_ELEMENTS = DEF_MAX_ELEMENTS,
  parameter int PHASE_BITS   = DEF_PHASE_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  vfs_in_if.sink                in_ch,
  vfs_out_if.source             out_ch
);

  localparam int AW = (MAX_DISHES > 1) ? $clog2(MAX_DISHES) : 1;
  localparam int DW = 2 * PHASE_BITS;

  logic          mem_wr_en, mem_rd_en, clr_busy;
  logic [AW-1:0] mem_wr_addr, rd_addr_row, rd_addr_col;
  logic [DW-1:0] rd_data_row, rd_data_col;
  dp_ctl_t       dp;

  // phase table
  vfs_phase_mem #(
    .MAX_DISHES (MAX_DISHES),
    .PHASE_BITS (PHASE_BITS)
  ) u_mem (
    .clk         (clk),
    .rst         (rst),
    .wr_en       (mem_wr_en),
    .wr_addr     (mem_wr_addr),
    .wr_data     ({in_ch.phase_re, in_ch.phase_im}),
    .rd_en       (mem_rd_en),
    .rd_addr_row (rd_addr_row),
    .rd_addr_col (rd_addr_col),
    .rd_data_row (rd_data_row),
    .rd_data_col (rd_data_col),
    .clr_busy    (clr_busy)
  );

  // control and position
  vfs_ctrl #(
    .MAX_DISHES   (MAX_DISHES),
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_idx     (cfg_idx),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_ch.valid),
    .in_mode     (in_ch.mode),
    .in_slot     (in_ch.phase_slot),
    .in_ready    (in_ch.ready),
    .out_ready   (out_ch.ready),
    .out_valid   (out_ch.valid),
    .out_last    (out_ch.last_of_frame),
    .clr_busy    (clr_busy),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_rd_en   (mem_rd_en),
    .rd_addr_row (rd_addr_row),
    .rd_addr_col (rd_addr_col),
    .dp          (dp)
  );

  // arithmetic
  vfs_mac #(
    .PHASE_BITS (PHASE_BITS)
  ) u_mac (
    .clk       (clk),
    .rst       (rst),
    .ctl       (dp),
    .in_vis_re (in_ch.vis_re),
    .in_vis_im (in_ch.vis_im),
    .row_phase (rd_data_row),
    .col_phase (rd_data_col),
    .out_re    (out_ch.out_re),
    .out_im    (out_ch.out_im)
  );

endmodule

@@ design/vfs_checker.sv @@
// ----------------------------------------------------------------------------
// vfs_checker
// port-level checks of the fringe-stop block, bound to the top level
// ----------------------------------------------------------------------------
module vfs_checker import vfs_pkg::*; (
  input logic                    clk,
  input logic                    rst,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    in_mode,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic signed [VIS_W-1:0] out_re,
  input logic signed [VIS_W-1:0] out_im,
  input logic                    out_last
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_re) && $stable(out_im) &&
                                $stable(out_last))
    else $error("result changed while stalled");

  // table sweep blocks requests right after reset
  a_clear_after_reset: assert property (@(posedge clk)
    $fell(rst) |-> !in_ready)
    else $error("request taken during table sweep");

  // a visibility request occupies the sequencer
  a_vis_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (in_mode == MODE_VIS) |=> !in_ready)
    else $error("request taken while a visibility is in work");

  // a phase request gives no result
  a_phase_silent: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (in_mode == MODE_PHASE) && !out_valid |=> !out_valid)
    else $error("phase request produced a result");

endmodule

bind visibility_fringe_stop_core vfs_checker u_vfs_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_mode   (in_ch.mode),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_re    (out_ch.out_re),
  .out_im    (out_ch.out_im),
  .out_last  (out_ch.last_of_frame)
);

@@ tb/visibility_fringe_stop_core_tb.sv @@
// ----------------------------------------------------------------------------
// visibility_fringe_stop_core_tb
// self-checking bench for the fringe-stop core: phase writes and upper-triangle
// visibilities go in over a valid/ready channel, and every corrected
// visibility is compared with a bit-true prediction of the phase table,
// triangle position and rounding/saturation rules. a directed opening covers
// saturation, every op mode, count clamping and position restarts. random
// frames follow with bursty idling on both channels.
// ----------------------------------------------------------------------------
module visibility_fringe_stop_core_tb import vfs_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PHASE_W  = DEF_PHASE_BITS;
  localparam int DISH_MAX = DEF_MAX_DISHES;
  localparam int ELEM_MAX = DEF_MAX_ELEMENTS;
  localparam int WIDE     = 66;

  // register index with no register behind it, and the op mode that aliases multiply
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE   = 2'd3;
  localparam logic [OP_MODE_W-1:0] OP_ALT_MULT = 2'd3;

  localparam int SETTLE_CYCLES = 16;
  localparam int TARGET_ITEMS  = 500;
  localparam int QUIET_ITEMS   = 420;
  localparam int DRAIN_LIMIT   = 4000;

  localparam logic signed [WIDE-1:0] HALF_LSB = 66'sd536870912;

  typedef struct packed {
    logic                      mode;
    logic [SLOT_W-1:0]         slot;
    logic signed [PHASE_W-1:0] ph_re;
    logic signed [PHASE_W-1:0] ph_im;
    logic signed [VIS_W-1:0]   vis_re;
    logic signed [VIS_W-1:0]   vis_im;
  } vis_req_t;

  typedef struct packed {
    logic signed [VIS_W-1:0] re;
    logic signed [VIS_W-1:0] im;
    logic                    last;
  } corrected_t;

  // phase table, triangle position and registers, plus the corrected
  // visibilities still owed by the block
  class fringe_scoreboard;
    logic signed [PHASE_W-1:0] tab_re [DISH_MAX];
    logic signed [PHASE_W-1:0] tab_im [DISH_MAX];
    int unsigned               row_idx, col_idx, row_dish, col_dish;
    logic [OP_MODE_W-1:0]      op_mode;
    logic [ELEM_CNT_W-1:0]     elem_cnt;
    logic [DISH_CNT_W-1:0]     dish_cnt;
    corrected_t                corrected_q[$];
    int unsigned               errors;

    function new();
      foreach (tab_re[k]) begin
        tab_re[k] = {1'b0, {(PHASE_W-1){1'b1}}};
        tab_im[k] = '0;
      end
      op_mode  = OP_MULT;
      elem_cnt = ELEM_CNT_W'(1);
      dish_cnt = DISH_CNT_W'(1);
      errors   = 0;
      home();
    endfunction

    function void home();
      row_idx  = 0;
      col_idx  = 0;
      row_dish = 0;
      col_dish = 0;
    endfunction

    function int pending();
      return corrected_q.size();
    endfunction

    function logic signed [VIS_W-1:0] clip(logic signed [WIDE-1:0] x);
      if (x > 66'sh0_7FFF_FFFF) return 32'sh7FFF_FFFF;
      if (x < -66'sh0_8000_0000) return 32'sh8000_0000;
      return x[VIS_W-1:0];
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_OP_MODE: op_mode = val[OP_MODE_W-1:0];
        CFG_ELEMENT_COUNT: begin
          elem_cnt = val[ELEM_CNT_W-1:0];
          home();
        end
        CFG_DISH_COUNT: begin
          dish_cnt = val[DISH_CNT_W-1:0];
          home();
        end
        default: ;
      endcase
    endfunction

    // note an accepted request and work out the corrected visibility it owes
    function void accept_request(vis_req_t r);
      int unsigned             e, d;
      logic signed [WIDE-1:0]  ar, ai, br, bi, vr, vi, pr_w, pi_w, acc_re, acc_im;
      logic signed [VIS_W-1:0] p_re, p_im;
      corrected_t              c;
      if (r.mode == MODE_PHASE) begin
        tab_re[r.slot] = r.ph_re;
        tab_im[r.slot] = r.ph_im;
        home();
        return;
      end
      e = (elem_cnt == 0) ? 1 : (elem_cnt > ELEM_MAX) ? ELEM_MAX : elem_cnt;
      d = (dish_cnt == 0) ? 1 : (dish_cnt > DISH_MAX) ? DISH_MAX : dish_cnt;
      if (row_idx >= e || col_idx >= e || row_dish >= d || col_dish >= d) home();

      // phase product row * conj(col), q30, saturated
      ar = WIDE'(tab_re[SLOT_W'(row_dish)]);
      ai = WIDE'(tab_im[SLOT_W'(row_dish)]);
      br = WIDE'(tab_re[SLOT_W'(col_dish)]);
      bi = WIDE'(tab_im[SLOT_W'(col_dish)]);
      p_re = clip(ar * br + ai * bi);
      p_im = clip(ai * br - ar * bi);

      // visibility times phase product, round half up, floor shift
      pr_w = WIDE'(p_re);
      pi_w = WIDE'(p_im);
      vr = WIDE'(r.vis_re);
      vi = WIDE'(r.vis_im);
      acc_re = (vr * pr_w - vi * pi_w + HALF_LSB) >>> 30;
      acc_im = (vr * pi_w + vi * pr_w + HALF_LSB) >>> 30;

      case (op_mode)
        OP_PASS: begin
          c.re = r.vis_re;
          c.im = r.vis_im;
        end
        OP_REPLACE: begin
          c.re = p_re;
          c.im = p_im;
        end
        default: begin
          c.re = clip(acc_re);
          c.im = clip(acc_im);
        end
      endcase
      c.last = (row_idx == e - 1) && (col_idx == e - 1);

      // step through the upper triangle, dishes wrapping by the dish count
      if (c.last) begin
        home();
      end else if (col_idx + 1 < e) begin
        col_idx++;
        col_dish = (col_dish + 1 >= d) ? 0 : col_dish + 1;
      end else begin
        row_idx++;
        row_dish = (row_dish + 1 >= d) ? 0 : row_dish + 1;
        col_idx  = row_idx;
        col_dish = row_dish;
      end
      corrected_q.push_back(c);
    endfunction

    // compare one accepted result with the oldest owed one
    function void check_result(corrected_t got);
      corrected_t want;
      if (corrected_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual re %0d im %0d last %0b",
                 $time, got.re, got.im, got.last);
        errors++;
        return;
      end
      want = corrected_q.pop_front();
      if (got.re !== want.re) begin
        $display("%0t: out_re mismatch, expected %0d, actual %0d", $time, want.re, got.re);
        errors++;
      end
      if (got.im !== want.im) begin
        $display("%0t: out_im mismatch, expected %0d, actual %0d", $time, want.im, got.im);
        errors++;
      end
      if (got.last !== want.last) begin
        $display("%0t: last_of_frame mismatch, expected %0b, actual %0b",
                 $time, want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  vfs_in_if  in_ch ();
  vfs_out_if out_ch ();

  fringe_scoreboard sb;
  vis_req_t         seen_req;
  corrected_t       seen_out;
  bit               in_low;
  bit               jitter = 1'b1;
  int unsigned      items_sent;

  visibility_fringe_stop_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch.sink),
    .out_ch    (out_ch.source)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // run limit
  initial begin
    #10ms;
    $display("Verification failed");
    $finish;
  end

  // result side: ready with random stall bursts
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (jitter && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
    end
  end

  // watch register writes and both handshakes
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_we) sb.write_register(cfg_idx, cfg_wdata);
      if (out_ch.valid && out_ch.ready) begin
        seen_out.re   = out_ch.out_re;
        seen_out.im   = out_ch.out_im;
        seen_out.last = out_ch.last_of_frame;
        sb.check_result(seen_out);
      end
      if (in_ch.valid && in_ch.ready) begin
        seen_req.mode   = in_ch.mode;
        seen_req.slot   = in_ch.phase_slot;
        seen_req.ph_re  = in_ch.phase_re;
        seen_req.ph_im  = in_ch.phase_im;
        seen_req.vis_re = in_ch.vis_re;
        seen_req.vis_im = in_ch.vis_im;
        sb.accept_request(seen_req);
      end
    end
  end

  function automatic logic [VIS_W-1:0] pick_word();
    case ($urandom_range(0, 11))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return '0;
      3: return '1;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [PHASE_W-1:0] pick_phase();
    case ($urandom_range(0, 9))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return '0;
      default: return PHASE_W'($urandom());
    endcase
  endfunction

  task automatic stop_input();
    if (!in_low) in_ch.valid <= 1'b0;
    in_low = 1'b1;
  endtask

  // present one request, optionally after an idle burst, and wait for accept
  task automatic send_request(input vis_req_t r);
    if (jitter && $urandom_range(0, 3) == 0) begin
      stop_input();
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.mode       <= r.mode;
    in_ch.phase_slot <= r.slot;
    in_ch.phase_re   <= r.ph_re;
    in_ch.phase_im   <= r.ph_im;
    in_ch.vis_re     <= r.vis_re;
    in_ch.vis_im     <= r.vis_im;
    in_low = 1'b0;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    items_sent++;
  endtask

  task automatic send_phase(input logic [SLOT_W-1:0] slot,
                            input logic signed [PHASE_W-1:0] re,
                            input logic signed [PHASE_W-1:0] im);
    vis_req_t r;
    r.mode   = MODE_PHASE;
    r.slot   = slot;
    r.ph_re  = re;
    r.ph_im  = im;
    r.vis_re = $urandom();
    r.vis_im = $urandom();
    send_request(r);
  endtask

  task automatic send_vis(input logic signed [VIS_W-1:0] re,
                          input logic signed [VIS_W-1:0] im);
    vis_req_t r;
    r.mode   = MODE_VIS;
    r.slot   = SLOT_W'($urandom());
    r.ph_re  = PHASE_W'($urandom());
    r.ph_im  = PHASE_W'($urandom());
    r.vis_re = re;
    r.vis_im = im;
    send_request(r);
  endtask

  task automatic hold_until_drained();
    stop_input();
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // idle the block fully before touching registers
  task automatic drain();
    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic reconfigure(input logic [OP_MODE_W-1:0] op,
                             input logic [CFG_DATA_W-1:0] elems,
                             input logic [CFG_DATA_W-1:0] dishes);
    drain();
    write_reg(CFG_OP_MODE, CFG_DATA_W'(op));
    write_reg(CFG_ELEMENT_COUNT, elems);
    write_reg(CFG_DISH_COUNT, dishes);
  endtask

  // stimulus
  initial begin
    int unsigned          e_sel, d_sel, tri_len, n_vis, round, waited;
    logic [OP_MODE_W-1:0] op_sel;
    sb = new();
    rst       <= 1'b1;
    cfg_we    <= 1'b0;
    cfg_idx   <= CFG_OP_MODE;
    cfg_wdata <= '0;
    in_ch.valid      <= 1'b0;
    in_ch.mode       <= MODE_PHASE;
    in_ch.phase_slot <= '0;
    in_ch.phase_re   <= '0;
    in_ch.phase_im   <= '0;
    in_ch.vis_re     <= '0;
    in_ch.vis_im     <= '0;
    in_low     = 1'b1;
    items_sent = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset registers: multiply by the near-unit phase, one-element frames
    send_vis(32'sh7FFF_FFFF, 32'sh8000_0000);
    reconfigure(OP_REPLACE, CFG_DATA_W'(1), CFG_DATA_W'(1));
    send_vis(0, 0);
    // most negative phase on both parts: product saturates
    send_phase(SLOT_W'(0), 16'sh8000, 16'sh8000);
    send_vis(1, -1);
    reconfigure(OP_MULT, CFG_DATA_W'(1), CFG_DATA_W'(1));
    send_vis(32'sh8000_0000, 32'sh8000_0000);
    send_vis(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    send_phase(SLOT_W'(0), 16'sh7FFF, 16'sh8000);
    send_vis(32'sh8000_0000, 32'sh7FFF_FFFF);
    // op mode three behaves as multiply
    reconfigure(OP_ALT_MULT, CFG_DATA_W'(1), CFG_DATA_W'(1));
    send_vis(pick_word(), pick_word());
    reconfigure(OP_PASS, CFG_DATA_W'(1), CFG_DATA_W'(1));
    send_vis(32'sh8000_0000, 32'sh7FFF_FFFF);
    // write to the spare register index changes nothing
    drain();
    write_reg(CFG_SPARE, '1);
    send_vis(pick_word(), pick_word());
    // three elements over two dishes: dish index wraps inside the frame
    reconfigure(OP_MULT, CFG_DATA_W'(3), CFG_DATA_W'(2));
    send_phase(SLOT_W'(0), pick_phase(), pick_phase());
    send_phase(SLOT_W'(1), pick_phase(), pick_phase());
    repeat (6) send_vis(pick_word(), pick_word());
    repeat (2) send_vis(pick_word(), pick_word());
    // phase write mid-frame restarts the triangle
    send_phase(9'h1FF, pick_phase(), pick_phase());
    send_vis(pick_word(), pick_word());
    // zero counts act as one
    reconfigure(OP_MULT, CFG_DATA_W'(0), CFG_DATA_W'(0));
    repeat (2) send_vis(pick_word(), pick_word());

    // random frames
    round = 0;
    while (items_sent < TARGET_ITEMS) begin
      jitter = (items_sent > QUIET_ITEMS) ? 1'b0 : ($urandom_range(0, 3) != 0);
      op_sel = OP_MODE_W'($urandom_range(0, 3));
      case (round)
        0: begin
          e_sel = 2047;
          d_sel = 1023;
        end
        1: begin
          e_sel = ELEM_MAX;
          d_sel = DISH_MAX;
        end
        2: begin
          e_sel = 1;
          d_sel = DISH_MAX;
        end
        default: begin
          if ($urandom_range(0, 7) == 0) begin
            e_sel = $urandom_range(0, 2047);
            d_sel = $urandom_range(0, 1023);
          end else begin
            e_sel = $urandom_range(1, 6);
            d_sel = $urandom_range(1, 8);
          end
        end
      endcase
      reconfigure(op_sel, CFG_DATA_W'(e_sel), CFG_DATA_W'(d_sel));

      // whole frames plus up to two items where small (at most 40), a short run into the big triangle otherwise
      if (e_sel >= 1 && e_sel <= 6) begin
        tri_len = e_sel * (e_sel + 1) / 2;
        n_vis = tri_len * $urandom_range(1, 3) + $urandom_range(0, 2);
        if (n_vis > 40) n_vis = 40;
      end else begin
        n_vis = 20;
      end

      // load up to the first eight dishes in use, plus one stray slot
      for (int k = 0; k < 8 && k < d_sel; k++)
        send_phase(SLOT_W'(k), pick_phase(), pick_phase());
      send_phase(SLOT_W'($urandom_range(0, DISH_MAX - 1)), pick_phase(), pick_phase());

      for (int k = 0; k < n_vis; k++) begin
        // stray phase write breaks the frame now and then
        if ($urandom_range(0, 19) == 0)
          send_phase(SLOT_W'($urandom_range(0, DISH_MAX - 1)), pick_phase(), pick_phase());
        if (round % 5 == 3 && k == n_vis / 2) hold_until_drained();
        send_vis(pick_word(), pick_word());
      end
      round++;
    end

    // wait out the last results
    stop_input();
    waited = 0;
    while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.pending() != 0) begin
      $display("%0t: results missing, expected %0d more, actual 0", $time, sb.pending());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
